FILE: sv/positional_list_engine_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the positional list engine
// Concurrent property wrappers that compile away when NO_ASSERTIONS is set.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication under an active-low reset.
`define PLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("positional_list_engine: assertion failed");
// Next-cycle implication under an active-low reset.
`define PLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("positional_list_engine: assertion failed");
`else
`define PLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/plen_pkg.sv
// ---------------------------------------------------------------------------
// Positional list engine package
// Field widths, command and status codes, and the command broadcast type.
// ---------------------------------------------------------------------------
package plen_pkg;

	localparam int unsigned DEF_CAPACITY = 16;

	localparam int unsigned KIND_W   = 2;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned POS_W    = 5;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned FIDX_W   = 5;
	localparam int unsigned LEN_W    = 5;

	// Command kinds.
	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOKEY  = 2'd3;

	typedef logic signed [VALUE_W-1:0] value_t;

	// Command broadcast to every cell of the row.
	typedef struct packed {
		logic                 load;   // a command word is accepted this cycle
		logic                 ins;    // insert that passed its checks
		logic                 del;    // delete that passed its checks
		logic                 srch;   // search command
		value_t               value;  // value to insert or key to match
		logic [POS_W-1:0]     pos;    // list position
	} plen_cmd_t;

endpackage

FILE: sv/plen_cell.sv
// ---------------------------------------------------------------------------
// Positional list cell
// Holds one list entry, shifts with its neighbors on insert and delete,
// and flags a key match or the removed entry for the result collector.
// ---------------------------------------------------------------------------
module plen_cell #(
	parameter int unsigned CAPACITY = plen_pkg::DEF_CAPACITY,
	parameter int unsigned INDEX    = 0
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  plen_pkg::plen_cmd_t                cmd,
	input  logic [$clog2(CAPACITY+1)-1:0]      count,
	input  plen_pkg::value_t                   left_val,
	input  plen_pkg::value_t                   right_val,
	output plen_pkg::value_t                   elem,
	output logic                               hit,
	output plen_pkg::value_t                   taken
);
	import plen_pkg::*;

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	value_t             elem_q;
	value_t             taken_q;
	logic               hit_q;
	logic [CMP_W-1:0]   pos_x;
	logic [CMP_W-1:0]   cnt_x;
	logic [CMP_W-1:0]   idx_x;
	logic               in_list;

	assign pos_x   = CMP_W'(cmd.pos);
	assign cnt_x   = CMP_W'(count);
	assign idx_x   = CMP_W'(INDEX);
	assign in_list = idx_x < cnt_x;

	// Entry storage: insert pulls from the left neighbor, delete from the right.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (cmd.ins) begin
				if (idx_x > pos_x) begin
					elem_q <= left_val;
				end else if (idx_x == pos_x) begin
					elem_q <= cmd.value;
				end
			end else if (cmd.del && idx_x >= pos_x) begin
				elem_q <= right_val;
			end
		end
	end

	// The cell at the delete position keeps its old entry for the result.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			taken_q <= (cmd.del && idx_x == pos_x) ? elem_q : '0;
		end
	end

	// Key match against a live entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmd.load) begin
			hit_q <= cmd.srch && in_list && (elem_q == cmd.value);
		end
	end

	assign elem  = elem_q;
	assign hit   = hit_q;
	assign taken = taken_q;

endmodule

FILE: sv/plen_collect.sv
// ---------------------------------------------------------------------------
// Positional list result collector
// Picks the lowest matching cell and merges the removed entry from the row.
// ---------------------------------------------------------------------------
module plen_collect #(
	parameter int unsigned CAPACITY = plen_pkg::DEF_CAPACITY
) (
	input  logic [CAPACITY-1:0]                hit,
	input  plen_pkg::value_t [CAPACITY-1:0]    taken,
	output logic                               any_hit,
	output logic [$clog2(CAPACITY)-1:0]        hit_idx,
	output plen_pkg::value_t                   removed
);
	import plen_pkg::*;

	localparam int unsigned IDX_W = $clog2(CAPACITY);

	// Lowest set hit wins; scanning downward lets the lowest index land last.
	always_comb begin
		hit_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (hit[i]) begin
				hit_idx = IDX_W'(i);
			end
		end
	end

	assign any_hit = |hit;

	// At most one cell holds a nonzero removed entry.
	always_comb begin
		removed = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			removed = removed | taken[i];
		end
	end

endmodule

FILE: sv/positional_list_engine.sv
// ---------------------------------------------------------------------------
// Positional list engine
// Ordered list of signed 32-bit values with positional insert and delete and
// first-match search, built as a row of shifting cells.
// ---------------------------------------------------------------------------
// In the cycle a command is accepted every cell shifts or loads in parallel and
// registers its match flag and any removed entry. From those registers the
// collector reduces the flags across the row into the result word, which lands
// in an output register once that register is empty or m_tready is high. One
// command is in flight at a time; the output register lets the next command be
// accepted while a result still waits on m_tready. Insert and delete shift the
// whole row at once, whatever the list length.
`include "positional_list_engine_defines.svh"

module positional_list_engine #(
	parameter int unsigned CAPACITY = plen_pkg::DEF_CAPACITY
) (
	input  logic        clk,
	input  logic        arst_n,
	// Command stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] value, [36:32] position, [39:37] zero
	input  logic [1:0]  s_tuser,   // [1:0] kind
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [31:0] removed_value, [36:32] found_index,
	                               // [41:37] length_now, [47:42] zero
	output logic [1:0]  m_tuser    // [1:0] status
);
	import plen_pkg::*;

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam int unsigned IDX_W = $clog2(CAPACITY);
	localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EVAL = 1'b1;

	logic                     state_q;
	logic [CNT_W-1:0]         count_q;
	logic [KIND_W-1:0]        kind_s1;
	logic [STATUS_W-1:0]      status_s1;

	logic                     s_acc;
	logic                     out_load;
	logic [KIND_W-1:0]        in_kind;
	value_t                   in_value;
	logic [POS_W-1:0]         in_pos;
	logic [CMP_W-1:0]         pos_x;
	logic [CMP_W-1:0]         cnt_x;
	logic                     ins_bad;
	logic                     ins_full;
	logic                     ins_ok;
	logic                     del_ok;
	logic [STATUS_W-1:0]      status_in;
	plen_cmd_t                cmd;

	value_t [CAPACITY-1:0]    elem_w;
	value_t [CAPACITY-1:0]    taken_w;
	logic   [CAPACITY-1:0]    hit_w;
	logic                     any_hit;
	logic [IDX_W-1:0]         hit_idx;
	value_t                   removed;

	logic                     m_valid_q;
	logic [STATUS_W-1:0]      status_q;
	value_t                   removed_q;
	logic [FIDX_W-1:0]        found_q;
	logic [LEN_W-1:0]         length_q;

	// Input word unpacking and command checks against the current length.
	assign in_kind  = s_tuser;
	assign in_value = s_tdata[31:0];
	assign in_pos   = s_tdata[36:32];
	assign pos_x    = CMP_W'(in_pos);
	assign cnt_x    = CMP_W'(count_q);
	assign ins_bad  = pos_x > cnt_x;
	assign ins_full = cnt_x == CMP_W'(CAPACITY);
	assign ins_ok   = (in_kind == KIND_INSERT) && !ins_bad && !ins_full;
	assign del_ok   = (in_kind == KIND_DELETE) && (pos_x < cnt_x);

	always_comb begin
		case (in_kind)
			KIND_INSERT: status_in = ins_bad ? ST_BADPOS : (ins_full ? ST_FULL : ST_OK);
			KIND_DELETE: status_in = del_ok ? ST_OK : ST_BADPOS;
			default:     status_in = ST_OK;
		endcase
	end

	assign s_tready = state_q == ST_IDLE;
	assign s_acc    = s_tvalid && s_tready;
	assign out_load = (state_q == ST_EVAL) && (!m_valid_q || m_tready);

	// Command broadcast to the cell row.
	assign cmd.load  = s_acc;
	assign cmd.ins   = ins_ok;
	assign cmd.del   = del_ok;
	assign cmd.srch  = in_kind == KIND_SEARCH;
	assign cmd.value = in_value;
	assign cmd.pos   = in_pos;

	// Row of cells; the ends see zero from the missing neighbor.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		value_t left_val;
		value_t right_val;

		if (g == 0) begin : g_first
			assign left_val = '0;
		end else begin : g_left
			assign left_val = elem_w[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign right_val = '0;
		end else begin : g_right
			assign right_val = elem_w[g+1];
		end

		plen_cell #(
			.CAPACITY (CAPACITY),
			.INDEX    (g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.count     (count_q),
			.left_val  (left_val),
			.right_val (right_val),
			.elem      (elem_w[g]),
			.hit       (hit_w[g]),
			.taken     (taken_w[g])
		);
	end

	plen_collect #(
		.CAPACITY (CAPACITY)
	) u_collect (
		.hit     (hit_w),
		.taken   (taken_w),
		.any_hit (any_hit),
		.hit_idx (hit_idx),
		.removed (removed)
	);

	// Sequencer and element count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						state_q <= ST_EVAL;
						if (ins_ok) begin
							count_q <= count_q + CNT_W'(1);
						end else if (del_ok) begin
							count_q <= count_q - CNT_W'(1);
						end
					end
				end
				ST_EVAL: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Command details carried to the result cycle.
	always_ff @(posedge clk) begin
		if (s_acc) begin
			kind_s1   <= in_kind;
			status_s1 <= status_in;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			removed_q <= removed;
			length_q  <= cnt_x[LEN_W-1:0];
			if (kind_s1 == KIND_SEARCH) begin
				status_q <= any_hit ? ST_OK : ST_NOKEY;
				found_q  <= any_hit ? FIDX_W'(hit_idx) : '1;
			end else begin
				status_q <= status_s1;
				found_q  <= '1;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {6'd0, length_q, found_q, removed_q};

	// Checks.
	`PLE_ASSERT_IMP(a_count_range, clk, arst_n, 1'b1, cnt_x <= CMP_W'(CAPACITY))
	`PLE_ASSERT_NXT(a_one_in_flight, clk, arst_n, s_acc, !s_tready)
	`PLE_ASSERT_NXT(a_delete_shrinks, clk, arst_n, s_acc && del_ok,
		count_q == $past(count_q) - CNT_W'(1))
	`PLE_ASSERT_NXT(a_insert_grows, clk, arst_n, s_acc && ins_ok,
		count_q == $past(count_q) + CNT_W'(1))

endmodule

FILE: test/tb_positional_list_engine.sv
// ---------------------------------------------------------------------------
// Testbench for the positional list engine
// Drives insert, delete and search commands through the command stream and
// checks every result word against a shadow copy of the list, under several
// patterns of sender gaps and receiver back-pressure.
// ---------------------------------------------------------------------------
module tb_positional_list_engine;

	import plen_pkg::*;

	localparam int unsigned CAPACITY    = DEF_CAPACITY;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned TAIL_CYCLES = 8;
	localparam int unsigned PHASE_ITEMS = 250;

	// The fourth command code is not defined by the block and must be ignored.
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam logic [FIDX_W-1:0] NO_INDEX    = 5'h1F;

	// One result word, split into its fields.
	typedef struct {
		logic [STATUS_W-1:0] status;
		value_t              removed_value;
		logic [FIDX_W-1:0]   found_index;
		logic [LEN_W-1:0]    length_now;
	} list_result_t;

	// Shadow copy of the list, the results it predicts, and the checker.
	class list_shadow;
		value_t       elements[CAPACITY];
		int           count;
		list_result_t pending_results[$];
		int           mismatches;

		function new();
			count      = 0;
			mismatches = 0;
		endfunction

		task report_mismatch(input string msg);
			$display("MISMATCH: %s", msg);
			mismatches++;
		endtask

		// Apply an accepted command to the shadow list and queue its result.
		function void apply_command(input logic [KIND_W-1:0] kind, input value_t value,
				input logic [POS_W-1:0] pos);
			list_result_t res;
			int           i;
			res.status        = ST_OK;
			res.removed_value = '0;
			res.found_index   = NO_INDEX;
			case (kind)
				KIND_INSERT: begin
					if (pos > count) begin
						res.status = ST_BADPOS;
					end else if (count >= CAPACITY) begin
						res.status = ST_FULL;
					end else begin
						for (i = count; i > pos; i--)
							elements[i] = elements[i-1];
						elements[pos] = value;
						count++;
					end
				end
				KIND_DELETE: begin
					if (pos >= count) begin
						res.status = ST_BADPOS;
					end else begin
						res.removed_value = elements[pos];
						for (i = pos; i + 1 < count; i++)
							elements[i] = elements[i+1];
						count--;
					end
				end
				KIND_SEARCH: begin
					res.status = ST_NOKEY;
					for (i = 0; i < count; i++) begin
						if (elements[i] == value && res.status == ST_NOKEY) begin
							res.status      = ST_OK;
							res.found_index = i[FIDX_W-1:0];
						end
					end
				end
				default: begin
				end
			endcase
			res.length_now = count[LEN_W-1:0];
			pending_results.push_back(res);
		endfunction

		// Compare a received result word with the oldest prediction.
		task check_result(input list_result_t got);
			list_result_t exp;
			if (pending_results.size() == 0) begin
				report_mismatch("result word arrived with no command outstanding");
			end else begin
				exp = pending_results.pop_front();
				if (got.status !== exp.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						got.status, exp.status));
				if (got.removed_value !== exp.removed_value)
					report_mismatch($sformatf("removed_value %0d, expected %0d",
						got.removed_value, exp.removed_value));
				if (got.found_index !== exp.found_index)
					report_mismatch($sformatf("found_index %0d, expected %0d",
						$signed(got.found_index), $signed(exp.found_index)));
				if (got.length_now !== exp.length_now)
					report_mismatch($sformatf("length_now %0d, expected %0d",
						got.length_now, exp.length_now));
			end
		endtask
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;   // [31:0] value, [36:32] position, [39:37] zero
	logic [1:0]  s_tuser  = '0;   // [1:0] kind
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;         // [31:0] removed_value, [36:32] found_index,
	                              // [41:37] length_now, [47:42] zero
	logic [1:0]  m_tuser;         // [1:0] status

	list_shadow  shadow;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;
	bit          pressure_on   = 1'b0;
	bit          hold_done     = 1'b0;
	int unsigned hold_left     = 0;
	int unsigned cycle_count   = 0;
	bit          fill_mode     = 1'b1;

	positional_list_engine #(.CAPACITY(CAPACITY)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	// Receiver: random stalls, plus long hold-offs in the pressure phase, the
	// first of them as soon as that phase starts.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else if (pressure_on && (!hold_done || $urandom_range(99) == 0)) begin
			hold_left = $urandom_range(120, 40);
			hold_done = 1'b1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Result monitor and run limit.
	always @(posedge clk) begin
		list_result_t got;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else if (arst_n && m_tvalid && m_tready) begin
			got.status        = m_tuser;
			got.removed_value = m_tdata[31:0];
			got.found_index   = m_tdata[36:32];
			got.length_now    = m_tdata[41:37];
			shadow.check_result(got);
		end
	end

	// Offer one command word and wait until the block takes it.
	task automatic send_command(input logic [KIND_W-1:0] kind, input value_t value,
			input logic [POS_W-1:0] pos);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, pos, value};
		s_tuser  <= kind;
		do @(posedge clk); while (!s_tready);
		shadow.apply_command(kind, value, pos);
	endtask

	// Values lean toward extremes and toward keys already in the list.
	function automatic value_t pick_value();
		value_t v;
		case ($urandom_range(9))
			0: v = 32'sh8000_0000;
			1: v = 32'sh7FFF_FFFF;
			2: v = -32'sd1;
			3: v = 32'sd0;
			4, 5: v = $signed(32'($urandom_range(7))) - 32'sd3;
			6, 7: v = (shadow.count > 0) ?
				shadow.elements[$urandom_range(shadow.count - 1)] : value_t'($urandom);
			default: v = value_t'($urandom);
		endcase
		return v;
	endfunction

	// Build one random command from the current shadow length.
	task automatic send_random_command();
		logic [KIND_W-1:0] kind;
		logic [POS_W-1:0]  pos;
		int unsigned       r;
		r = $urandom_range(99);
		if ($urandom_range(29) == 0)
			fill_mode = ~fill_mode;
		if (r < 2)
			kind = KIND_UNUSED;
		else if (r < 22)
			kind = KIND_SEARCH;
		else if ($urandom_range(99) < (fill_mode ? 70 : 30))
			kind = KIND_INSERT;
		else
			kind = KIND_DELETE;
		if ($urandom_range(9) == 0)
			pos = 5'($urandom_range(31));
		else if (kind == KIND_INSERT)
			pos = 5'($urandom_range(shadow.count));
		else
			pos = (shadow.count > 0) ? 5'($urandom_range(shadow.count - 1)) : 5'd0;
		send_command(kind, pick_value(), pos);
	endtask

	initial begin
		shadow = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty list, single element, ends, middle, duplicates, full.
		send_command(KIND_SEARCH, 32'sd5, 5'd0);
		send_command(KIND_DELETE, 32'sd0, 5'd0);
		send_command(KIND_DELETE, 32'sd0, 5'd31);
		send_command(KIND_INSERT, 32'sd9, 5'd1);
		send_command(KIND_INSERT, 32'sh8000_0000, 5'd0);
		send_command(KIND_DELETE, 32'sd0, 5'd0);
		send_command(KIND_INSERT, 32'sh7FFF_FFFF, 5'd0);
		send_command(KIND_INSERT, 32'sh8000_0000, 5'd1);
		send_command(KIND_INSERT, 32'sd0, 5'd1);
		send_command(KIND_INSERT, -32'sd1, 5'd0);
		send_command(KIND_SEARCH, 32'sh8000_0000, 5'd0);
		send_command(KIND_UNUSED, 32'sh5A5A_A5A5, 5'd31);
		send_command(KIND_DELETE, 32'sd0, 5'd4);
		send_command(KIND_DELETE, 32'sd0, 5'd3);
		send_command(KIND_DELETE, 32'sd0, 5'd1);
		while (shadow.count < CAPACITY)
			send_command(KIND_INSERT, 32'sd7, 5'(shadow.count));
		send_command(KIND_INSERT, 32'sd1, 5'd16);
		send_command(KIND_INSERT, 32'sd1, 5'd17);
		send_command(KIND_SEARCH, 32'sd7, 5'd0);
		send_command(KIND_DELETE, 32'sd0, 5'd15);

		// Random phases with different idling patterns.
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  pressure_on = 1'b0; end
				1: begin send_idle_pct = 45; stall_pct = 0;  pressure_on = 1'b0; end
				2: begin send_idle_pct = 0;  stall_pct = 45; pressure_on = 1'b0; end
				3: begin send_idle_pct = 25; stall_pct = 25; pressure_on = 1'b0; end
				default: begin send_idle_pct = 0; stall_pct = 0; pressure_on = 1'b1; end
			endcase
			repeat (PHASE_ITEMS) send_random_command();
		end
		s_tvalid    <= 1'b0;
		stall_pct   = 0;
		pressure_on = 1'b0;

		// Drain outstanding results, then watch for stray words.
		while (shadow.pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (shadow.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+sv
sv/plen_pkg.sv
sv/plen_cell.sv
sv/plen_collect.sv
sv/positional_list_engine.sv
test/tb_positional_list_engine.sv
